// File: rtl/cst_pkg.sv
// Shared constants, token kind codes and byte classification helpers
// for the character stream tokenizer. No dependencies.
`default_nettype none

package cst_pkg;

    // Default field widths
    localparam int LINE_BITS_DEF   = 16;
    localparam int COLUMN_BITS_DEF = 12;
    localparam int LENGTH_BITS_DEF = 8;
    localparam int KIND_BITS       = 4;
    localparam int CHAR_BITS       = 8;

    // Token queue between front and back
    localparam int QUEUE_DEPTH = 4;
    localparam int QPTR_BITS   = $clog2(QUEUE_DEPTH);
    localparam int QLVL_BITS   = $clog2(QUEUE_DEPTH + 1);

    // Token kinds
    localparam logic [KIND_BITS-1:0] K_END       = 4'd0;
    localparam logic [KIND_BITS-1:0] K_IDENT     = 4'd1;
    localparam logic [KIND_BITS-1:0] K_NUMBER    = 4'd2;
    localparam logic [KIND_BITS-1:0] K_ADD       = 4'd3;
    localparam logic [KIND_BITS-1:0] K_SUB       = 4'd4;
    localparam logic [KIND_BITS-1:0] K_MUL       = 4'd5;
    localparam logic [KIND_BITS-1:0] K_LPAREN    = 4'd6;
    localparam logic [KIND_BITS-1:0] K_RPAREN    = 4'd7;
    localparam logic [KIND_BITS-1:0] K_LCURLY    = 4'd8;
    localparam logic [KIND_BITS-1:0] K_RCURLY    = 4'd9;
    localparam logic [KIND_BITS-1:0] K_SEMICOLON = 4'd10;
    localparam logic [KIND_BITS-1:0] K_LSQUARE   = 4'd11;
    localparam logic [KIND_BITS-1:0] K_RSQUARE   = 4'd12;
    localparam logic [KIND_BITS-1:0] K_HASH      = 4'd13;
    localparam logic [KIND_BITS-1:0] K_ERROR     = 4'd14;

    // Open run kinds
    localparam logic [1:0] RUN_NONE   = 2'd0;
    localparam logic [1:0] RUN_IDENT  = 2'd1;
    localparam logic [1:0] RUN_NUMBER = 2'd2;

    // Characters of interest
    localparam logic [CHAR_BITS-1:0] CH_NUL    = 8'h00;
    localparam logic [CHAR_BITS-1:0] CH_TAB    = 8'h09;
    localparam logic [CHAR_BITS-1:0] CH_NL     = 8'h0A;
    localparam logic [CHAR_BITS-1:0] CH_VT     = 8'h0B;
    localparam logic [CHAR_BITS-1:0] CH_SPACE  = 8'h20;
    localparam logic [CHAR_BITS-1:0] CH_HASH   = 8'h23;
    localparam logic [CHAR_BITS-1:0] CH_LPAREN = 8'h28;
    localparam logic [CHAR_BITS-1:0] CH_RPAREN = 8'h29;
    localparam logic [CHAR_BITS-1:0] CH_STAR   = 8'h2A;
    localparam logic [CHAR_BITS-1:0] CH_PLUS   = 8'h2B;
    localparam logic [CHAR_BITS-1:0] CH_MINUS  = 8'h2D;
    localparam logic [CHAR_BITS-1:0] CH_DIG0   = 8'h30;
    localparam logic [CHAR_BITS-1:0] CH_DIG9   = 8'h39;
    localparam logic [CHAR_BITS-1:0] CH_SEMI   = 8'h3B;
    localparam logic [CHAR_BITS-1:0] CH_UPA    = 8'h41;
    localparam logic [CHAR_BITS-1:0] CH_UPZ    = 8'h5A;
    localparam logic [CHAR_BITS-1:0] CH_LSQ    = 8'h5B;
    localparam logic [CHAR_BITS-1:0] CH_RSQ    = 8'h5D;
    localparam logic [CHAR_BITS-1:0] CH_UNDER  = 8'h5F;
    localparam logic [CHAR_BITS-1:0] CH_LOA    = 8'h61;
    localparam logic [CHAR_BITS-1:0] CH_LOZ    = 8'h7A;
    localparam logic [CHAR_BITS-1:0] CH_LCURLY = 8'h7B;
    localparam logic [CHAR_BITS-1:0] CH_RCURLY = 8'h7D;

    // Queue status seen by the top level
    typedef struct packed {
        logic                 full;
        logic                 empty;
        logic [QLVL_BITS-1:0] level;
    } queue_status_t;

    function automatic logic is_letter(input logic [CHAR_BITS-1:0] c);
        return ((c >= CH_LOA) && (c <= CH_LOZ)) ||
               ((c >= CH_UPA) && (c <= CH_UPZ)) || (c == CH_UNDER);
    endfunction

    function automatic logic is_digit(input logic [CHAR_BITS-1:0] c);
        return (c >= CH_DIG0) && (c <= CH_DIG9);
    endfunction

    function automatic logic [KIND_BITS-1:0] punct_kind(input logic [CHAR_BITS-1:0] c);
        logic [KIND_BITS-1:0] k;
        unique case (c)
            CH_PLUS:   k = K_ADD;
            CH_MINUS:  k = K_SUB;
            CH_STAR:   k = K_MUL;
            CH_LPAREN: k = K_LPAREN;
            CH_RPAREN: k = K_RPAREN;
            CH_LCURLY: k = K_LCURLY;
            CH_RCURLY: k = K_RCURLY;
            CH_SEMI:   k = K_SEMICOLON;
            CH_LSQ:    k = K_LSQUARE;
            CH_RSQ:    k = K_RSQUARE;
            CH_HASH:   k = K_HASH;
            default:   k = K_ERROR;
        endcase
        return k;
    endfunction

endpackage

`default_nettype wire

// File: rtl/char_stream_tokenizer_core.sv
// Top level of the character stream tokenizer: front end, token queue and
// back end. Depends on cst_pkg, cst_front, cst_queue and cst_back.
`default_nettype none

// Channel   Dir  Word                         Side band
// s_        in   tdata[7:0] = source byte     none
// m_        out  tdata = kind, line, column,  tlast = last token of the byte
//                length (from bit 0 up)
//
// Flow: one byte is taken every cycle while the four-entry token queue
// has room; a token passes the queue slot and then the output register.
// Bytes that emit two tokens (a closed run plus punctuation or end) send
// them one after the other; the queue absorbs bursts of those, after which
// s_tready follows the output drain of one token per cycle while m_tready is high.
// Reset clears the open run, line and column counters, queue and output.
// A stall on m_ backs up into the queue and only then into s_tready.

module char_stream_tokenizer_core
    import cst_pkg::*;
#(
    parameter int LINE_BITS   = LINE_BITS_DEF,
    parameter int COLUMN_BITS = COLUMN_BITS_DEF,
    parameter int LENGTH_BITS = LENGTH_BITS_DEF,
    localparam int TOK_W      = KIND_BITS + LINE_BITS + COLUMN_BITS + LENGTH_BITS,
    localparam int DATA_W     = ((TOK_W + 7) / 8) * 8
) (
    input  wire logic                 aclk,
    input  wire logic                 aresetn,
    input  wire logic                 s_tvalid,
    output logic                      s_tready,
    input  wire logic [CHAR_BITS-1:0] s_tdata,   // ch
    output logic                      m_tvalid,
    input  wire logic                 m_tready,
    output logic      [DATA_W-1:0]    m_tdata,   // tok_kind, tok_line, tok_column, tok_length
    output logic                      m_tlast    // last_of_item
);

    localparam int ENTRY_W = 2 * TOK_W + 1;

    logic               accept;
    logic               q_push, q_pop;
    logic [ENTRY_W-1:0] q_wr, q_rd;
    queue_status_t      q_st;
    logic               back_pend;
    logic [TOK_W-1:0]   out_tok;

    // hold input whenever the queue is full
    assign s_tready = !q_st.full;
    assign accept   = s_tvalid && s_tready;

    cst_front #(
        .LINE_BITS  (LINE_BITS),
        .COLUMN_BITS(COLUMN_BITS),
        .LENGTH_BITS(LENGTH_BITS)
    ) u_front (
        .aclk   (aclk),
        .aresetn(aresetn),
        .accept (accept),
        .ch     (s_tdata),
        .push   (q_push),
        .entry  (q_wr)
    );

    cst_queue #(
        .WIDTH(ENTRY_W)
    ) u_queue (
        .aclk   (aclk),
        .aresetn(aresetn),
        .push   (q_push),
        .wr_data(q_wr),
        .pop    (q_pop),
        .rd_data(q_rd),
        .status (q_st)
    );

    cst_back #(
        .TOK_W(TOK_W)
    ) u_back (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .entry    (q_rd),
        .q_empty  (q_st.empty),
        .pop      (q_pop),
        .pend     (back_pend),
        .out_valid(m_tvalid),
        .out_tok  (out_tok),
        .out_last (m_tlast),
        .out_ready(m_tready)
    );

    // pad the token up to whole bytes
    assign m_tdata = DATA_W'(out_tok);

    // queue never holds more entries than it has slots
    assert property (@(posedge aclk) disable iff (!aresetn)
        q_st.level <= QLVL_BITS'(QUEUE_DEPTH))
        else $error("token queue level beyond depth");

    // no entry is written into a full queue
    assert property (@(posedge aclk) disable iff (!aresetn)
        q_push |-> !q_st.full)
        else $error("push into full token queue");

    // a shown token that is not the last of its byte has its partner waiting
    assert property (@(posedge aclk) disable iff (!aresetn)
        (m_tvalid && !m_tlast) |-> back_pend)
        else $error("first token shown without pending second token");

    // nothing is popped while the second token of an entry is still due
    assert property (@(posedge aclk) disable iff (!aresetn)
        back_pend |-> !q_pop)
        else $error("queue popped while a token is pending");

endmodule

`default_nettype wire

// File: rtl/cst_front.sv
// Front end: accepts source bytes, classifies them, tracks the open run
// and position, and pushes up to two finished tokens per byte. Uses cst_pkg.
`default_nettype none

module cst_front
    import cst_pkg::*;
#(
    parameter int LINE_BITS   = LINE_BITS_DEF,
    parameter int COLUMN_BITS = COLUMN_BITS_DEF,
    parameter int LENGTH_BITS = LENGTH_BITS_DEF,
    localparam int TOK_W      = KIND_BITS + LINE_BITS + COLUMN_BITS + LENGTH_BITS,
    localparam int ENTRY_W    = 2 * TOK_W + 1
) (
    input  wire logic                 aclk,
    input  wire logic                 aresetn,
    input  wire logic                 accept,
    input  wire logic [CHAR_BITS-1:0] ch,
    output logic                      push,
    output logic [ENTRY_W-1:0]        entry
);

    logic [1:0]             run_kind_reg,   run_kind_next;
    logic [LENGTH_BITS-1:0] run_len_reg,    run_len_next;
    logic [LINE_BITS-1:0]   run_line_reg,   run_line_next;
    logic [COLUMN_BITS-1:0] run_col_reg,    run_col_next;
    logic [LINE_BITS-1:0]   cur_line_reg,   cur_line_next;
    logic [COLUMN_BITS-1:0] cur_col_reg,    cur_col_next;

    logic                   letter, digit, alnum, blank, newline, nul;
    logic                   run_open, run_cont, run_close, own_tok;
    logic [TOK_W-1:0]       run_tok, own_tok_data;
    logic [KIND_BITS-1:0]   own_kind;
    logic [LENGTH_BITS-1:0] own_len;
    logic [COLUMN_BITS-1:0] col_adv;

    always_comb begin
        letter    = is_letter(ch);
        digit     = is_digit(ch);
        alnum     = letter || digit;
        nul       = (ch == CH_NUL);
        newline   = (ch == CH_NL);
        blank     = (ch == CH_SPACE) || (ch == CH_TAB) || (ch == CH_VT);
        run_open  = (run_kind_reg != RUN_NONE);
        run_cont  = run_open && alnum;
        run_close = run_open && !alnum;
        own_tok   = !alnum && !newline && !blank;
        col_adv   = (cur_col_reg != '1) ? cur_col_reg + 1'b1 : cur_col_reg;

        own_kind = nul ? K_END : punct_kind(ch);
        own_len  = nul ? '0 : LENGTH_BITS'(1);

        run_tok      = {run_len_reg, run_col_reg, run_line_reg,
                        KIND_BITS'(run_kind_reg)};
        own_tok_data = {own_len, cur_col_reg, cur_line_reg, own_kind};

        push = accept && (run_close || own_tok);
        if (run_close) begin
            entry = {own_tok, own_tok_data, run_tok};
        end else begin
            entry = {1'b0, own_tok_data, own_tok_data};
        end
    end

    always_comb begin
        run_kind_next = run_kind_reg;
        run_len_next  = run_len_reg;
        run_line_next = run_line_reg;
        run_col_next  = run_col_reg;
        cur_line_next = cur_line_reg;
        cur_col_next  = cur_col_reg;
        if (run_cont) begin
            // extend the open run
            if (run_len_reg != '1) begin
                run_len_next = run_len_reg + 1'b1;
            end
            cur_col_next = col_adv;
        end else begin
            if (run_close) begin
                run_kind_next = RUN_NONE;
                run_len_next  = '0;
            end
            priority if (nul) begin
                // end of text: restart position for the next text
                cur_line_next = '0;
                cur_col_next  = '0;
            end else if (alnum) begin
                run_kind_next = letter ? RUN_IDENT : RUN_NUMBER;
                run_len_next  = LENGTH_BITS'(1);
                run_line_next = cur_line_reg;
                run_col_next  = cur_col_reg;
                cur_col_next  = col_adv;
            end else if (newline) begin
                if (cur_line_reg != '1) begin
                    cur_line_next = cur_line_reg + 1'b1;
                end
                cur_col_next = '0;
            end else begin
                cur_col_next = col_adv;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            run_kind_reg <= RUN_NONE;
            run_len_reg  <= '0;
            run_line_reg <= '0;
            run_col_reg  <= '0;
            cur_line_reg <= '0;
            cur_col_reg  <= '0;
        end else if (accept) begin
            run_kind_reg <= run_kind_next;
            run_len_reg  <= run_len_next;
            run_line_reg <= run_line_next;
            run_col_reg  <= run_col_next;
            cur_line_reg <= cur_line_next;
            cur_col_reg  <= cur_col_next;
        end
    end

endmodule

`default_nettype wire

// File: rtl/cst_queue.sv
// Short FIFO of token entries between front and back end.
// Uses cst_pkg for depth and status type.
`default_nettype none

module cst_queue
    import cst_pkg::*;
#(
    parameter int WIDTH = 1
) (
    input  wire logic             aclk,
    input  wire logic             aresetn,
    input  wire logic             push,
    input  wire logic [WIDTH-1:0] wr_data,
    input  wire logic             pop,
    output logic      [WIDTH-1:0] rd_data,
    output queue_status_t         status
);

    logic [WIDTH-1:0]     slot_reg [QUEUE_DEPTH];
    logic [QPTR_BITS-1:0] wr_ptr_reg, rd_ptr_reg;
    logic [QLVL_BITS-1:0] level_reg,  level_next;

    always_comb begin
        status.level = level_reg;
        status.empty = (level_reg == '0);
        status.full  = (level_reg == QLVL_BITS'(QUEUE_DEPTH));
        rd_data      = slot_reg[rd_ptr_reg];
        level_next   = level_reg;
        if (push && !pop) begin
            level_next = level_reg + 1'b1;
        end else if (pop && !push) begin
            level_next = level_reg - 1'b1;
        end
    end

    always_ff @(posedge aclk) begin
        if (push) begin
            slot_reg[wr_ptr_reg] <= wr_data;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            level_reg  <= '0;
        end else begin
            if (push) begin
                wr_ptr_reg <= (wr_ptr_reg == QPTR_BITS'(QUEUE_DEPTH - 1)) ? '0
                              : wr_ptr_reg + 1'b1;
            end
            if (pop) begin
                rd_ptr_reg <= (rd_ptr_reg == QPTR_BITS'(QUEUE_DEPTH - 1)) ? '0
                              : rd_ptr_reg + 1'b1;
            end
            level_reg <= level_next;
        end
    end

endmodule

`default_nettype wire

// File: rtl/cst_back.sv
// Back end: pops token entries and sends their tokens one per word through
// a registered output stage. Uses cst_pkg.
`default_nettype none

module cst_back
    import cst_pkg::*;
#(
    parameter int TOK_W   = KIND_BITS + 1,
    localparam int ENTRY_W = 2 * TOK_W + 1
) (
    input  wire logic               aclk,
    input  wire logic               aresetn,
    input  wire logic [ENTRY_W-1:0] entry,
    input  wire logic               q_empty,
    output logic                    pop,
    output logic                    pend,
    output logic                    out_valid,
    output logic      [TOK_W-1:0]   out_tok,
    output logic                    out_last,
    input  wire logic               out_ready
);

    logic             valid_reg;
    logic [TOK_W-1:0] tok_reg;
    logic             last_reg;
    logic             pend_reg;
    logic [TOK_W-1:0] second_reg;
    logic             out_free;

    always_comb begin
        out_free  = !valid_reg || out_ready;
        // take a new entry only once its predecessor's second token is out
        pop       = out_free && !pend_reg && !q_empty;
        pend      = pend_reg;
        out_valid = valid_reg;
        out_tok   = tok_reg;
        out_last  = last_reg;
    end

    always_ff @(posedge aclk) begin
        if (out_free) begin
            if (pend_reg) begin
                tok_reg  <= second_reg;
                last_reg <= 1'b1;
            end else if (pop) begin
                tok_reg    <= entry[TOK_W-1:0];
                second_reg <= entry[2*TOK_W-1:TOK_W];
                last_reg   <= !entry[2*TOK_W];
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            valid_reg <= 1'b0;
            pend_reg  <= 1'b0;
        end else if (out_free) begin
            if (pend_reg) begin
                valid_reg <= 1'b1;
                pend_reg  <= 1'b0;
            end else begin
                valid_reg <= pop;
                pend_reg  <= pop && entry[2*TOK_W];
            end
        end
    end

endmodule

`default_nettype wire
